>>> design/h3fp_pkg.sv
package h3fp_pkg;

    // Parser phase. The varint type and length come first, and then one phase
    // for each field of the frame kind.
    typedef enum logic [3:0] {
        PH_TYPE,
        PH_LEN,
        PH_PTYPES,
        PH_PID1,
        PH_PID2,
        PH_PWEIGHT,
        PH_ONE,
        PH_SETID,
        PH_SETVAL,
        PH_PAYLOAD,
        PH_SKIP
    } phase_t;

    typedef logic [61:0] value_t;

    // Event kinds. Frame kinds are stored with the same codes.
    localparam logic [3:0] EV_DATA          = 4'd0;
    localparam logic [3:0] EV_HEADERS       = 4'd1;
    localparam logic [3:0] EV_PRIORITY      = 4'd2;
    localparam logic [3:0] EV_CANCEL_PUSH   = 4'd3;
    localparam logic [3:0] EV_SETTING       = 4'd4;
    localparam logic [3:0] EV_SETTINGS_END  = 4'd5;
    localparam logic [3:0] EV_PROMISED_PUSH = 4'd6;
    localparam logic [3:0] EV_GOAWAY        = 4'd7;
    localparam logic [3:0] EV_MAX_PUSH_ID   = 4'd8;
    localparam logic [3:0] EV_DUP_PUSH      = 4'd9;
    localparam logic [3:0] EV_PAYLOAD_BYTE  = 4'd10;
    localparam logic [3:0] EV_MALFORMED     = 4'd11;
    localparam logic [3:0] KIND_UNKNOWN     = 4'd15;

    // Frame type codes on the wire.
    localparam value_t FT_DATA          = 62'h0;
    localparam value_t FT_HEADERS       = 62'h1;
    localparam value_t FT_PRIORITY      = 62'h2;
    localparam value_t FT_CANCEL_PUSH   = 62'h3;
    localparam value_t FT_SETTINGS      = 62'h4;
    localparam value_t FT_PROMISED_PUSH = 62'h5;
    localparam value_t FT_GOAWAY        = 62'h7;
    localparam value_t FT_MAX_PUSH_ID   = 62'hD;
    localparam value_t FT_DUP_PUSH      = 62'hE;

    // Setting identifiers and their slots.
    localparam value_t SID_MAX_HEADER_LIST = 62'h6;
    localparam value_t SID_PLACEHOLDERS    = 62'h9;
    localparam value_t SID_QPACK_CAPACITY  = 62'h1;
    localparam value_t SID_QPACK_BLOCKED   = 62'h7;

    localparam logic [2:0] SLOT_MAX_HEADER_LIST = 3'd0;
    localparam logic [2:0] SLOT_PLACEHOLDERS    = 3'd1;
    localparam logic [2:0] SLOT_QPACK_CAPACITY  = 3'd2;
    localparam logic [2:0] SLOT_QPACK_BLOCKED   = 3'd3;
    localparam logic [2:0] SLOT_NONE            = 3'd4;

    typedef struct packed {
        logic [3:0] kind;
        value_t     first;
        value_t     second;
        logic [1:0] slot;
        logic [1:0] pkind;
        logic [1:0] dkind;
        logic [7:0] weight;
        logic       last;
    } event_t;

    function automatic logic [3:0] kind_of(input value_t t);
        logic [3:0] k;
        begin
            unique case (t)
                FT_DATA:          k = EV_DATA;
                FT_HEADERS:       k = EV_HEADERS;
                FT_PRIORITY:      k = EV_PRIORITY;
                FT_CANCEL_PUSH:   k = EV_CANCEL_PUSH;
                FT_SETTINGS:      k = EV_SETTING;
                FT_PROMISED_PUSH: k = EV_PROMISED_PUSH;
                FT_GOAWAY:        k = EV_GOAWAY;
                FT_MAX_PUSH_ID:   k = EV_MAX_PUSH_ID;
                FT_DUP_PUSH:      k = EV_DUP_PUSH;
                default:          k = KIND_UNKNOWN;
            endcase
            return k;
        end
    endfunction

    function automatic logic [2:0] slot_of(input value_t id);
        logic [2:0] s;
        begin
            unique case (id)
                SID_MAX_HEADER_LIST: s = SLOT_MAX_HEADER_LIST;
                SID_PLACEHOLDERS:    s = SLOT_PLACEHOLDERS;
                SID_QPACK_CAPACITY:  s = SLOT_QPACK_CAPACITY;
                SID_QPACK_BLOCKED:   s = SLOT_QPACK_BLOCKED;
                default:             s = SLOT_NONE;
            endcase
            return s;
        end
    endfunction

endpackage

>>> design/http3_frame_stream_parser.sv
// HTTP/3 frame stream parser.
// The stream channel (stream_valid, stream_ready, stream_byte) takes one byte of
// a control or request stream per request. The event channel (event_valid,
// event_ready and the event fields) gives the decoded events: frame headers,
// priority fields, setting entries, forwarded payload bytes and a malformed
// marker. A byte causes zero, one or two events; last marks the final event of
// its byte.
// Each accepted byte is decoded in the cycle it is accepted, against the parser
// state registers, and its events are written into a four-entry event queue.
// The first event of a byte appears on the event channel in the cycle after the
// byte is accepted when the queue is empty, later when older events wait ahead
// of it. One byte is taken every cycle while the queue has room for two events,
// so the sustained rate is one byte per clock; a byte with two events writes
// both into the queue at once, and the event channel gives them out one by one.
// When the receiver stalls the queue fills and stream_ready drops once fewer
// than two entries are free; no event is lost.
// Reset empties the queue and returns the parser to the frame type phase. After
// a malformed event the parser keeps taking bytes but ignores them until reset.
module http3_frame_stream_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stream_valid,
    output logic                stream_ready,
    input  logic [7:0]          stream_byte,
    output logic                event_valid,
    input  logic                event_ready,
    output logic [3:0]          event_kind,
    output h3fp_pkg::value_t    first_value,
    output h3fp_pkg::value_t    second_value,
    output logic [1:0]          setting_slot,
    output logic [1:0]          prioritized_kind,
    output logic [1:0]          dependency_kind,
    output logic [7:0]          weight,
    output logic                last
);
    import h3fp_pkg::*;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Parser state.
    phase_t     phase_reg, phase_next;
    value_t     acc_reg, acc_next;
    logic [2:0] left_reg, left_next;
    logic [3:0] kind_reg, kind_next;
    value_t     adv_reg, adv_next;
    value_t     cons_reg, cons_next;
    value_t     held_id_reg, held_id_next;
    logic [2:0] held_slot_reg, held_slot_next;
    logic [3:0] held_types_reg, held_types_next;
    logic       halted_reg, halted_next;

    // Event queue.
    event_t            fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  head_reg, tail_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic       accept;
    logic       pop;
    value_t     feed_acc;
    logic [2:0] feed_left;
    logic       feed_done;
    value_t     cons_cur;
    event_t     ev0, ev1;
    logic [1:0] n_ev;
    event_t     head_ev;

    assign accept       = stream_valid && stream_ready;
    assign stream_ready = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign event_valid  = (count_reg != '0);
    assign pop          = event_valid && event_ready;

    // One step of the QUIC varint decoder: the top two bits of the first byte
    // give the length, later bytes shift in below the bits already held.
    always_comb
    begin
        if (left_reg == 3'd0)
        begin
            feed_acc = {56'd0, stream_byte[5:0]};
            case (stream_byte[7:6])
                2'd0:    feed_left = 3'd0;
                2'd1:    feed_left = 3'd1;
                2'd2:    feed_left = 3'd3;
                default: feed_left = 3'd7;
            endcase
        end
        else
        begin
            feed_acc  = {acc_reg[53:0], stream_byte};
            feed_left = left_reg - 3'd1;
        end
        feed_done = (feed_left == 3'd0);
        // The byte count covers payload bytes only.
        cons_cur = (phase_reg == PH_TYPE || phase_reg == PH_LEN) ? cons_reg
                                                                 : cons_reg + 62'd1;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        left_next       = left_reg;
        kind_next       = kind_reg;
        adv_next        = adv_reg;
        cons_next       = cons_reg;
        held_id_next    = held_id_reg;
        held_slot_next  = held_slot_reg;
        held_types_next = held_types_reg;
        halted_next     = halted_reg;
        ev0             = '0;
        ev1             = '0;
        n_ev            = 2'd0;

        if (accept && !halted_reg)
        begin
            cons_next = cons_cur;
            unique case (phase_reg)
                PH_TYPE:
                begin
                    acc_next  = feed_acc;
                    left_next = feed_left;
                    if (feed_done)
                    begin
                        kind_next  = kind_of(feed_acc);
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    acc_next  = feed_acc;
                    left_next = feed_left;
                    if (feed_done)
                    begin
                        adv_next  = feed_acc;
                        cons_next = '0;
                        case (kind_reg)
                            EV_DATA, EV_HEADERS:
                            begin
                                ev0.kind   = kind_reg;
                                ev0.first  = feed_acc;
                                n_ev       = 2'd1;
                                phase_next = (feed_acc == '0) ? PH_TYPE : PH_PAYLOAD;
                            end
                            EV_PRIORITY:
                            begin
                                phase_next = PH_PTYPES;
                            end
                            EV_SETTING:
                            begin
                                if (feed_acc == '0)
                                begin
                                    ev0.kind   = EV_SETTINGS_END;
                                    n_ev       = 2'd1;
                                    phase_next = PH_TYPE;
                                end
                                else
                                begin
                                    phase_next = PH_SETID;
                                end
                            end
                            KIND_UNKNOWN:
                            begin
                                phase_next = (feed_acc == '0) ? PH_TYPE : PH_SKIP;
                            end
                            default:
                            begin
                                phase_next = PH_ONE;
                            end
                        endcase
                    end
                end
                PH_PTYPES:
                begin
                    held_types_next = {stream_byte[7:6], stream_byte[5:4]};
                    phase_next      = PH_PID1;
                end
                PH_PID1:
                begin
                    acc_next  = feed_acc;
                    left_next = feed_left;
                    if (feed_done)
                    begin
                        held_id_next = feed_acc;
                        phase_next   = PH_PID2;
                    end
                end
                PH_PID2:
                begin
                    // The dependency id stays in the accumulator until the weight.
                    acc_next  = feed_acc;
                    left_next = feed_left;
                    if (feed_done)
                    begin
                        phase_next = PH_PWEIGHT;
                    end
                end
                PH_PWEIGHT:
                begin
                    n_ev = 2'd1;
                    if (cons_cur != adv_reg)
                    begin
                        ev0.kind    = EV_MALFORMED;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        ev0.kind   = EV_PRIORITY;
                        ev0.first  = held_id_reg;
                        ev0.second = acc_reg;
                        ev0.pkind  = held_types_reg[3:2];
                        ev0.dkind  = held_types_reg[1:0];
                        ev0.weight = stream_byte;
                    end
                    phase_next = PH_TYPE;
                end
                PH_ONE:
                begin
                    acc_next  = feed_acc;
                    left_next = feed_left;
                    if (feed_done)
                    begin
                        n_ev       = 2'd1;
                        phase_next = PH_TYPE;
                        if (kind_reg == EV_PROMISED_PUSH)
                        begin
                            // The push id may be followed by a header block
                            // that is forwarded byte by byte.
                            if (cons_cur > adv_reg)
                            begin
                                ev0.kind    = EV_MALFORMED;
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                ev0.kind   = EV_PROMISED_PUSH;
                                ev0.first  = feed_acc;
                                ev0.second = adv_reg - cons_cur;
                                if (cons_cur < adv_reg)
                                begin
                                    phase_next = PH_PAYLOAD;
                                end
                            end
                        end
                        else if (cons_cur != adv_reg)
                        begin
                            ev0.kind    = EV_MALFORMED;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            ev0.kind  = kind_reg;
                            ev0.first = feed_acc;
                        end
                    end
                end
                PH_SETID:
                begin
                    acc_next  = feed_acc;
                    left_next = feed_left;
                    if (feed_done)
                    begin
                        held_slot_next = slot_of(feed_acc);
                        phase_next     = PH_SETVAL;
                    end
                end
                PH_SETVAL:
                begin
                    acc_next  = feed_acc;
                    left_next = feed_left;
                    if (feed_done)
                    begin
                        // A known entry goes first; the end marker or the
                        // malformed event may follow from the same byte.
                        if (held_slot_reg != SLOT_NONE)
                        begin
                            ev0.kind  = EV_SETTING;
                            ev0.first = feed_acc;
                            ev0.slot  = held_slot_reg[1:0];
                        end
                        if (cons_cur < adv_reg)
                        begin
                            phase_next = PH_SETID;
                            n_ev       = (held_slot_reg != SLOT_NONE) ? 2'd1 : 2'd0;
                        end
                        else
                        begin
                            phase_next = PH_TYPE;
                            if (cons_cur != adv_reg)
                            begin
                                halted_next = 1'b1;
                            end
                            if (held_slot_reg != SLOT_NONE)
                            begin
                                ev1.kind = (cons_cur == adv_reg) ? EV_SETTINGS_END
                                                                 : EV_MALFORMED;
                                n_ev     = 2'd2;
                            end
                            else
                            begin
                                ev0.kind = (cons_cur == adv_reg) ? EV_SETTINGS_END
                                                                 : EV_MALFORMED;
                                n_ev     = 2'd1;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    ev0.kind  = EV_PAYLOAD_BYTE;
                    ev0.first = {54'd0, stream_byte};
                    n_ev      = 2'd1;
                    if (cons_cur >= adv_reg)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_SKIP:
                begin
                    if (cons_cur >= adv_reg)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                default:
                begin
                    phase_next = PH_TYPE;
                    left_next  = 3'd0;
                end
            endcase
        end

        if (n_ev == 2'd1)
        begin
            ev0.last = 1'b1;
        end
        else if (n_ev == 2'd2)
        begin
            ev1.last = 1'b1;
        end

        count_next = count_reg + CNT_W'(n_ev) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TYPE;
            acc_reg        <= '0;
            left_reg       <= '0;
            kind_reg       <= '0;
            adv_reg        <= '0;
            cons_reg       <= '0;
            held_id_reg    <= '0;
            held_slot_reg  <= '0;
            held_types_reg <= '0;
            halted_reg     <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            left_reg       <= left_next;
            kind_reg       <= kind_next;
            adv_reg        <= adv_next;
            cons_reg       <= cons_next;
            held_id_reg    <= held_id_next;
            held_slot_reg  <= held_slot_next;
            held_types_reg <= held_types_next;
            halted_reg     <= halted_next;
            head_reg       <= head_reg + PTR_W'(pop);
            tail_reg       <= tail_reg + PTR_W'(n_ev);
            count_reg      <= count_next;
        end
    end

    // Queue entries carry payload only.
    always_ff @(posedge clk)
    begin
        if (n_ev != 2'd0)
        begin
            fifo_reg[tail_reg] <= ev0;
        end
        if (n_ev == 2'd2)
        begin
            fifo_reg[tail_reg + PTR_W'(1)] <= ev1;
        end
    end

    assign head_ev          = fifo_reg[head_reg];
    assign event_kind       = head_ev.kind;
    assign first_value      = head_ev.first;
    assign second_value     = head_ev.second;
    assign setting_slot     = head_ev.slot;
    assign prioritized_kind = head_ev.pkind;
    assign dependency_kind  = head_ev.dkind;
    assign weight           = head_ev.weight;
    assign last             = head_ev.last;

    // The queue never holds more entries than it has.
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("event queue overflow");

    // Once halted, accepted bytes add no events.
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg && accept |=> count_reg <= $past(count_reg))
        else $error("event produced after halt");

    // A malformed event always closes the events of its byte.
    a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_kind == EV_MALFORMED |-> last)
        else $error("malformed event not marked last");

    // A forwarded payload byte always reaches the queue.
    a_payload_push: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !halted_reg && phase_reg == PH_PAYLOAD |=> count_reg != '0)
        else $error("payload byte lost");

endmodule

>>> tb/tb_top.sv
module tb_top;

    import h3fp_pkg::*;

    // Receiver behavior. The mode is drawn anew whenever its countdown runs out so
    // that stretches of full rate alternate with short and long stalls.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PERIODIC,
        RX_LONG
    } rx_mode_t;

    // One pending request on the stream channel. The hold flag makes the
    // sender wait until every expected event has been seen before offering it.
    typedef struct {
        logic [7:0] b;
        bit         hold;
    } stream_item_t;

    localparam value_t VALUE_MAX = '1;

    // Frame types that carry exactly one varint field.
    localparam value_t ONE_FIELD_TYPES [4] = '{
        FT_CANCEL_PUSH, FT_GOAWAY, FT_MAX_PUSH_ID, FT_DUP_PUSH
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       stream_valid = 1'b0;
    logic       stream_ready;
    logic [7:0] stream_byte = 8'd0;
    logic       event_valid;
    logic       event_ready = 1'b0;
    logic [3:0] event_kind;
    value_t     first_value;
    value_t     second_value;
    logic [1:0] setting_slot;
    logic [1:0] prioritized_kind;
    logic [1:0] dependency_kind;
    logic [7:0] weight;
    logic       last;

    http3_frame_stream_parser i_dut (
        .clk,
        .rst_n,
        .stream_valid,
        .stream_ready,
        .stream_byte,
        .event_valid,
        .event_ready,
        .event_kind,
        .first_value,
        .second_value,
        .setting_slot,
        .prioritized_kind,
        .dependency_kind,
        .weight,
        .last
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser state as the testbench tracks it. It is advanced once per
    // accepted request, in the same order as the hardware sees the bytes.
    // ------------------------------------------------------------------
    phase_t     ph = PH_TYPE;
    value_t     acc = '0;
    logic [2:0] vleft = 3'd0;
    logic [3:0] fkind = EV_DATA;
    value_t     flen = '0;
    value_t     used = '0;
    value_t     id_hold = '0;
    logic [2:0] slot_hold = SLOT_MAX_HEADER_LIST;
    logic [3:0] types_hold = 4'd0;
    logic       stopped = 1'b0;

    // Events caused by the byte being decoded; a byte causes at most two.
    event_t     step_ev [2];
    int         step_n;

    // Events still to come out of the block, oldest first.
    event_t     expected_events [$];
    int         n_predicted = 0;
    int         n_checked = 0;
    int         errors = 0;

    // Stimulus.
    stream_item_t pending_bytes [$];
    stream_item_t item;
    logic [7:0]   body [$];
    bit           hold_next = 1'b0;
    int           n_queued = 0;
    int           bytes_taken = 0;
    int           burst_left = 0;
    int           gap_left = 0;

    // Receiver stall pattern.
    rx_mode_t   rx_mode = RX_FREE;
    int         rx_left = 0;
    int         rx_hold = 0;
    event_t     want;

    function automatic logic [3:0] frame_kind_of(input value_t t);
        case (t)
            FT_DATA:          return EV_DATA;
            FT_HEADERS:       return EV_HEADERS;
            FT_PRIORITY:      return EV_PRIORITY;
            FT_CANCEL_PUSH:   return EV_CANCEL_PUSH;
            FT_SETTINGS:      return EV_SETTING;
            FT_PROMISED_PUSH: return EV_PROMISED_PUSH;
            FT_GOAWAY:        return EV_GOAWAY;
            FT_MAX_PUSH_ID:   return EV_MAX_PUSH_ID;
            FT_DUP_PUSH:      return EV_DUP_PUSH;
            default:          return KIND_UNKNOWN;
        endcase
    endfunction

    function automatic logic [2:0] slot_for(input value_t id);
        case (id)
            SID_MAX_HEADER_LIST: return SLOT_MAX_HEADER_LIST;
            SID_PLACEHOLDERS:    return SLOT_PLACEHOLDERS;
            SID_QPACK_CAPACITY:  return SLOT_QPACK_CAPACITY;
            SID_QPACK_BLOCKED:   return SLOT_QPACK_BLOCKED;
            default:             return SLOT_NONE;
        endcase
    endfunction

    // Shifts one byte into the varint being assembled. The two top bits of
    // the first byte give the encoded length: 1, 2, 4 or 8 bytes. Returns
    // true once the value is complete.
    function automatic logic varint_take(input logic [7:0] b);
        if (vleft == 3'd0)
        begin
            acc = value_t'(b[5:0]);
            vleft = 3'((4'd1 << b[7:6]) - 4'd1);
        end
        else
        begin
            acc = {acc[53:0], b};
            vleft = vleft - 3'd1;
        end
        return vleft == 3'd0;
    endfunction

    task automatic note(input logic [3:0] k, input value_t f, input value_t s,
                        input logic [1:0] sl, input logic [1:0] pk,
                        input logic [1:0] dk, input logic [7:0] w);
        step_ev[step_n] = '{kind: k, first: f, second: s, slot: sl, pkind: pk,
                            dkind: dk, weight: w, last: 1'b0};
        step_n++;
    endtask

    // A malformed frame gives one event, and the parser then ignores every
    // byte until reset.
    task automatic mark_malformed();
        note(EV_MALFORMED, '0, '0, 2'd0, 2'd0, 2'd0, 8'd0);
        stopped = 1'b1;
    endtask

    // The length varint is complete: decide how the payload is read.
    task automatic open_payload();
        flen = acc;
        used = '0;
        case (fkind)
            EV_DATA, EV_HEADERS:
            begin
                note(fkind, flen, '0, 2'd0, 2'd0, 2'd0, 8'd0);
                if (flen == '0)
                    ph = PH_TYPE;
                else
                    ph = PH_PAYLOAD;
            end
            EV_PRIORITY:
                ph = PH_PTYPES;
            EV_SETTING:
            begin
                if (flen == '0)
                begin
                    note(EV_SETTINGS_END, '0, '0, 2'd0, 2'd0, 2'd0, 8'd0);
                    ph = PH_TYPE;
                end
                else
                    ph = PH_SETID;
            end
            KIND_UNKNOWN:
            begin
                if (flen == '0)
                    ph = PH_TYPE;
                else
                    ph = PH_SKIP;
            end
            default:
                ph = PH_ONE;
        endcase
    endtask

    // Decodes one accepted stream byte and appends the events it causes to
    // the expected queue, with last set on the final one.
    task automatic decode_byte(input logic [7:0] b);
        step_n = 0;
        if (!stopped)
        begin
            // Every byte after the frame header counts against the length.
            if (ph != PH_TYPE && ph != PH_LEN)
                used = used + 62'd1;
            case (ph)
                PH_TYPE:
                begin
                    if (varint_take(b))
                    begin
                        fkind = frame_kind_of(acc);
                        ph = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (varint_take(b))
                        open_payload();
                end
                PH_PTYPES:
                begin
                    types_hold = {b[7:6], b[5:4]};
                    ph = PH_PID1;
                end
                PH_PID1:
                begin
                    if (varint_take(b))
                    begin
                        id_hold = acc;
                        ph = PH_PID2;
                    end
                end
                PH_PID2:
                begin
                    // The dependency id stays in the accumulator.
                    if (varint_take(b))
                        ph = PH_PWEIGHT;
                end
                PH_PWEIGHT:
                begin
                    if (used != flen)
                        mark_malformed();
                    else
                        note(EV_PRIORITY, id_hold, acc, 2'd0, types_hold[3:2],
                             types_hold[1:0], b);
                    ph = PH_TYPE;
                end
                PH_ONE:
                begin
                    if (varint_take(b))
                    begin
                        if (fkind == EV_PROMISED_PUSH)
                        begin
                            if (used > flen)
                                mark_malformed();
                            else
                                note(EV_PROMISED_PUSH, acc, flen - used, 2'd0, 2'd0,
                                     2'd0, 8'd0);
                            if (!stopped && used < flen)
                                ph = PH_PAYLOAD;
                            else
                                ph = PH_TYPE;
                        end
                        else
                        begin
                            if (used != flen)
                                mark_malformed();
                            else
                                note(fkind, acc, '0, 2'd0, 2'd0, 2'd0, 8'd0);
                            ph = PH_TYPE;
                        end
                    end
                end
                PH_SETID:
                begin
                    if (varint_take(b))
                    begin
                        slot_hold = slot_for(acc);
                        ph = PH_SETVAL;
                    end
                end
                PH_SETVAL:
                begin
                    if (varint_take(b))
                    begin
                        // Entries with an unknown id are dropped.
                        if (slot_hold != SLOT_NONE)
                            note(EV_SETTING, acc, '0, slot_hold[1:0], 2'd0, 2'd0,
                                 8'd0);
                        if (used < flen)
                            ph = PH_SETID;
                        else
                        begin
                            if (used == flen)
                                note(EV_SETTINGS_END, '0, '0, 2'd0, 2'd0, 2'd0, 8'd0);
                            else
                                mark_malformed();
                            ph = PH_TYPE;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    note(EV_PAYLOAD_BYTE, value_t'(b), '0, 2'd0, 2'd0, 2'd0, 8'd0);
                    if (used >= flen)
                        ph = PH_TYPE;
                end
                PH_SKIP:
                begin
                    if (used >= flen)
                        ph = PH_TYPE;
                end
                default:
                begin
                    ph = PH_TYPE;
                    vleft = 3'd0;
                end
            endcase
        end
        for (int i = 0; i < step_n; i++)
        begin
            step_ev[i].last = (i == step_n - 1);
            expected_events.push_back(step_ev[i]);
            n_predicted++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stream construction. Frame bodies are built in body, and send_frame
    // puts the type, the length and the body on the pending queue.
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back('{b, hold_next});
        hold_next = 1'b0;
        n_queued++;
    endtask

    // Values are spread over the four varint sizes so that long encodings
    // and wide values come up often.
    function automatic value_t rand_val();
        case ($urandom_range(0, 3))
            0:       return value_t'($urandom_range(0, 63));
            1:       return value_t'($urandom_range(0, 16383));
            2:       return value_t'($urandom & 32'h3FFF_FFFF);
            default: return value_t'({$urandom, $urandom});
        endcase
    endfunction

    // Smallest encoding that holds the value, but now and then a wider one,
    // which the parser must accept as well.
    function automatic logic [1:0] pick_size(input value_t v);
        logic [1:0] s;
        if (v < 62'd64)
            s = 2'd0;
        else if (v < 62'd16384)
            s = 2'd1;
        else if (v < 62'h4000_0000)
            s = 2'd2;
        else
            s = 2'd3;
        if ($urandom_range(0, 4) == 0)
            s = 2'($urandom_range(3, s));
        return s;
    endfunction

    task automatic put_varint(input value_t v, input bit into_body);
        logic [1:0]  sz;
        logic [63:0] enc;
        int          nb;
        sz = pick_size(v);
        nb = 1 << sz;
        enc = {2'b00, v} | (64'(sz) << (8 * nb - 2));
        for (int i = nb - 1; i >= 0; i--)
        begin
            if (into_body)
                body.push_back(enc[8 * i +: 8]);
            else
                push_byte(enc[8 * i +: 8]);
        end
    endtask

    task automatic send_frame(input value_t ftype, input value_t len);
        put_varint(ftype, 1'b0);
        put_varint(len, 1'b0);
        foreach (body[i])
            push_byte(body[i]);
        body.delete();
    endtask

    task automatic fill_random(input int n);
        for (int i = 0; i < n; i++)
            body.push_back(8'($urandom));
    endtask

    // Payload sizes stay small most of the time, with a few longer runs.
    function automatic int pick_count();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(7, 40);
        return $urandom_range(0, 6);
    endfunction

    task automatic build_priority(input logic [1:0] pt, input logic [1:0] dt,
                                  input value_t pid, input value_t did,
                                  input logic [7:0] w);
        // The low nibble of the types byte is reserved and must be ignored.
        body.push_back({pt, dt, 4'($urandom)});
        put_varint(pid, 1'b1);
        put_varint(did, 1'b1);
        body.push_back(w);
    endtask

    task automatic build_settings(input int npairs);
        value_t id;
        for (int p = 0; p < npairs; p++)
        begin
            case ($urandom_range(0, 5))
                0: id = SID_MAX_HEADER_LIST;
                1: id = SID_PLACEHOLDERS;
                2: id = SID_QPACK_CAPACITY;
                3: id = SID_QPACK_BLOCKED;
                default:
                    do
                        id = rand_val();
                    while (slot_for(id) != SLOT_NONE);
            endcase
            put_varint(id, 1'b1);
            put_varint(rand_val(), 1'b1);
        end
    endtask

    function automatic value_t unknown_type();
        value_t t;
        do
            t = rand_val();
        while (frame_kind_of(t) != KIND_UNKNOWN);
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Sender. Requests come off the pending queue in bursts of random length
    // with random gaps between them. A request stays on the channel with its
    // byte unchanged until the parser takes it.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_valid <= 1'b0;
            stream_byte <= 8'd0;
            ph = PH_TYPE;
            acc = '0;
            vleft = 3'd0;
            fkind = EV_DATA;
            flen = '0;
            used = '0;
            id_hold = '0;
            slot_hold = SLOT_MAX_HEADER_LIST;
            types_hold = 4'd0;
            stopped = 1'b0;
        end
        else
        begin
            if (stream_valid && stream_ready)
            begin
                decode_byte(stream_byte);
                bytes_taken++;
            end
            // The channel is free for a new request unless one is waiting.
            if (!stream_valid || stream_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    stream_valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0 &&
                         (!pending_bytes[0].hold || n_predicted == n_checked))
                begin
                    item = pending_bytes.pop_front();
                    stream_valid <= 1'b1;
                    stream_byte <= item.b;
                    if (burst_left <= 1)
                    begin
                        if ($urandom_range(0, 5) == 0)
                            burst_left = $urandom_range(30, 80);
                        else
                            burst_left = $urandom_range(1, 12);
                        if ($urandom_range(0, 6) == 0)
                            gap_left = $urandom_range(8, 20);
                        else
                            gap_left = $urandom_range(0, 3);
                    end
                    else
                        burst_left--;
                end
                else
                    stream_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string what, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (got_v !== exp_v)
        begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, what, exp_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker. Every event taken from the block is compared
    // field by field with the oldest expected event. n_checked is updated
    // with a nonblocking assignment so that the sender reads a settled count
    // at the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_ready <= 1'b0;
        end
        else
        begin
            if (event_valid && event_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    errors++;
                    $display("%0t: event kind %0h arrived with nothing expected",
                             $time, event_kind);
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_kind", 64'(want.kind), 64'(event_kind));
                    check_field("first_value", 64'(want.first), 64'(first_value));
                    check_field("second_value", 64'(want.second), 64'(second_value));
                    check_field("setting_slot", 64'(want.slot), 64'(setting_slot));
                    check_field("prioritized_kind", 64'(want.pkind),
                                64'(prioritized_kind));
                    check_field("dependency_kind", 64'(want.dkind),
                                64'(dependency_kind));
                    check_field("weight", 64'(want.weight), 64'(weight));
                    check_field("last", 64'(want.last), 64'(last));
                    n_checked <= n_checked + 1;
                end
            end

            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(40, 250);
            end
            else
                rx_left--;
            case (rx_mode)
                RX_FREE:
                    event_ready <= 1'b1;
                RX_RANDOM:
                    event_ready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC:
                    event_ready <= (rx_left % 3 == 0);
                default:
                begin
                    if (rx_hold > 0)
                    begin
                        rx_hold--;
                        event_ready <= 1'b0;
                    end
                    else
                    begin
                        event_ready <= 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            rx_hold = $urandom_range(5, 30);
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin : main_flow
        int random_start;
        int mode;
        value_t ftype;

        // Directed part. A zero-length DATA frame gives its size event only.
        send_frame(FT_DATA, '0);
        // HEADERS forwarding both extreme byte values.
        body.push_back(8'h00);
        body.push_back(8'hFF);
        send_frame(FT_HEADERS, value_t'(body.size()));
        // PRIORITY with the widest prioritized id and the extreme field values.
        build_priority(2'd3, 2'd3, VALUE_MAX, '0, 8'h00);
        send_frame(FT_PRIORITY, value_t'(body.size()));
        build_priority(2'd0, 2'd2, '0, 62'd77, 8'hFF);
        send_frame(FT_PRIORITY, value_t'(body.size()));
        // The one-field frames, with zero and the largest value.
        put_varint('0, 1'b1);
        send_frame(FT_CANCEL_PUSH, value_t'(body.size()));
        put_varint(VALUE_MAX, 1'b1);
        send_frame(FT_GOAWAY, value_t'(body.size()));
        put_varint(62'd1, 1'b1);
        send_frame(FT_MAX_PUSH_ID, value_t'(body.size()));
        put_varint(62'd63, 1'b1);
        send_frame(FT_DUP_PUSH, value_t'(body.size()));
        // Empty SETTINGS: the end marker comes from the length byte.
        send_frame(FT_SETTINGS, '0);
        // An unknown id is dropped; the last known entry and the end marker
        // come from the same byte.
        put_varint(62'h21, 1'b1);
        put_varint(62'd5, 1'b1);
        put_varint(SID_QPACK_BLOCKED, 1'b1);
        put_varint(62'd100, 1'b1);
        send_frame(FT_SETTINGS, value_t'(body.size()));
        // A promised push with nothing after the id, then one with payload.
        put_varint(62'd5, 1'b1);
        send_frame(FT_PROMISED_PUSH, value_t'(body.size()));
        put_varint(62'd300, 1'b1);
        fill_random(2);
        send_frame(FT_PROMISED_PUSH, value_t'(body.size()));
        // Unknown frame types are skipped, with and without a payload.
        fill_random(3);
        send_frame(62'h21, value_t'(body.size()));
        send_frame(unknown_type(), '0);

        // Random part: well-formed frames with random content, and unknown
        // frames as noise. The sender drains the block at its start and now
        // and then along the way.
        hold_next = 1'b1;
        random_start = n_queued;
        while (n_queued - random_start < 370)
        begin
            if ($urandom_range(0, 40) == 0)
                hold_next = 1'b1;
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    fill_random(pick_count());
                    send_frame(FT_DATA, value_t'(body.size()));
                end
                3, 4, 5:
                begin
                    fill_random(pick_count());
                    send_frame(FT_HEADERS, value_t'(body.size()));
                end
                6, 7:
                begin
                    build_priority(2'($urandom), 2'($urandom), rand_val(), rand_val(),
                                   8'($urandom));
                    send_frame(FT_PRIORITY, value_t'(body.size()));
                end
                8, 9, 10, 11:
                begin
                    put_varint(rand_val(), 1'b1);
                    send_frame(ONE_FIELD_TYPES[$urandom_range(0, 3)],
                               value_t'(body.size()));
                end
                12, 13, 14:
                begin
                    build_settings($urandom_range(0, 4));
                    send_frame(FT_SETTINGS, value_t'(body.size()));
                end
                15, 16:
                begin
                    put_varint(rand_val(), 1'b1);
                    fill_random(pick_count());
                    send_frame(FT_PROMISED_PUSH, value_t'(body.size()));
                end
                default:
                begin
                    fill_random(pick_count());
                    send_frame(unknown_type(), value_t'(body.size()));
                end
            endcase
        end

        // A malformed frame closes the stream, since the parser stays halted
        // until reset. Which length error it is varies from run to run.
        hold_next = 1'b1;
        mode = $urandom_range(0, 3);
        case (mode)
            0, 1:
            begin
                // Fixed-size frame whose advertised length is off by one.
                if (mode == 0)
                begin
                    put_varint(rand_val(), 1'b1);
                    ftype = ONE_FIELD_TYPES[$urandom_range(0, 3)];
                end
                else
                begin
                    build_priority(2'($urandom), 2'($urandom), rand_val(), rand_val(),
                                   8'($urandom));
                    ftype = FT_PRIORITY;
                end
                if ($urandom_range(0, 1) == 0)
                    send_frame(ftype, value_t'(body.size() + 1));
                else
                    send_frame(ftype, value_t'(body.size() - 1));
            end
            2:
            begin
                // The last settings pair runs past the length.
                build_settings($urandom_range(1, 3));
                send_frame(FT_SETTINGS, value_t'(body.size() - 1));
            end
            default:
            begin
                // A push id of two or more bytes in a one- or zero-byte frame.
                put_varint(rand_val() | 62'h40, 1'b1);
                send_frame(FT_PROMISED_PUSH, value_t'($urandom_range(0, 1)));
            end
        endcase
        // Bytes after the malformed frame are taken but cause nothing.
        for (int i = 0; i < 12; i++)
            push_byte(8'($urandom));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (bytes_taken == n_queued);
        wait (n_checked == n_predicted);
        // Anything the block sends from here on is unexpected.
        repeat (80) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
